### rtl/core/psod_pkg.sv
package psod_pkg;

	localparam int MAX_LINE_LENGTH_DEF = 4096;
	localparam int MIN_LINE_LENGTH     = 7;
	localparam int MAX_RESULTS         = 7;
	localparam int WIN_CELLS           = 7;
	localparam int LEAD_CELLS          = 6;
	localparam int RES_DEPTH           = 16;
	localparam int RSV_LIMIT           = RES_DEPTH - MAX_RESULTS;

	localparam logic [12:0] LINE_LENGTH_RST = 13'd100;
	localparam logic [23:0] INV_SPACING_RST = 24'd65536;

	localparam logic [0:0] REG_LINE_LENGTH = 1'b0;
	localparam logic [0:0] REG_INV_SPACING = 1'b1;

	localparam logic signed [24:0] TAP_A = 25'sd279620;
	localparam logic signed [24:0] TAP_B = 25'sd2516582;
	localparam logic signed [24:0] TAP_C = 25'sd12582912;

	typedef logic signed [31:0] smp_t;

	typedef struct packed {
		logic signed [31:0] sample;
	} sample_word_t;

	typedef struct packed {
		logic signed [31:0] derivative;
		logic [11:0]        position;
		logic               line_done;
	} result_word_t;

	typedef struct packed {
		logic [11:0] position;
		logic        line_done;
	} tag_t;

endpackage

### rtl/core/psod_if.sv
interface psod_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/core/psod_cell.sv
module psod_cell
	import psod_pkg::*;
(
	input  logic clk,
	input  logic en,
	input  smp_t d,
	output smp_t q
);

	smp_t val_q;

	always_ff @(posedge clk) begin
		if (en) begin
			val_q <= d;
		end
	end

	assign q = val_q;

endmodule

### rtl/core/psod_derive.sv
module psod_derive
	import psod_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         iss,
	input  tag_t         tag,
	input  smp_t         win [WIN_CELLS],
	input  logic [23:0]  inv_spacing,
	output logic         res_valid,
	output result_word_t res
);

	logic signed [32:0] d_a, d_b, d_c;
	logic signed [57:0] pa_s1, pb_s1, pc_s1;
	logic signed [59:0] acc;
	logic signed [35:0] sum_s2;
	logic signed [60:0] prod_s3;
	logic signed [60:0] rnd;
	logic signed [44:0] r;
	logic               v_s1, v_s2, v_s3;
	tag_t               tag_s1, tag_s2, tag_s3;

	assign d_a = 33'(win[6]) - 33'(win[0]);
	assign d_b = 33'(win[1]) - 33'(win[5]);
	assign d_c = 33'(win[4]) - 33'(win[2]);

	always_ff @(posedge clk) begin
		pa_s1 <= 58'(d_a) * 58'(TAP_A);
		pb_s1 <= 58'(d_b) * 58'(TAP_B);
		pc_s1 <= 58'(d_c) * 58'(TAP_C);
		tag_s1 <= tag;
	end

	// tap sum rounded half up to q.20
	assign acc = 60'(pa_s1) + 60'(pb_s1) + 60'(pc_s1) + 60'sd8388608;

	always_ff @(posedge clk) begin
		sum_s2 <= 36'(acc >>> 24);
		tag_s2 <= tag_s1;
	end

	always_ff @(posedge clk) begin
		prod_s3 <= 61'(sum_s2) * 61'($signed({1'b0, inv_spacing}));
		tag_s3  <= tag_s2;
	end

	assign rnd = prod_s3 + 61'sd32768;
	assign r   = 45'(rnd >>> 16);

	always_comb begin
		res.position  = tag_s3.position;
		res.line_done = tag_s3.line_done;
		if (r > 45'sd2147483647) begin
			res.derivative = 32'sh7fffffff;
		end else if (r < -45'sd2147483648) begin
			res.derivative = 32'sh80000000;
		end else begin
			res.derivative = r[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= iss;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign res_valid = v_s3;

endmodule

### rtl/core/psod_fifo.sv
module psod_fifo
	import psod_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  result_word_t push_data,
	psod_if.source       results
);

	localparam int PW = $clog2(RES_DEPTH);
	localparam int CNW = $clog2(RES_DEPTH + 1);

	result_word_t   mem_q [RES_DEPTH];
	logic [PW-1:0]  wr_q, rd_q;
	logic [CNW-1:0] cnt_q;
	logic           pop;

	assign results.valid = cnt_q != '0;
	assign results.data  = mem_q[rd_q];
	assign pop           = results.valid && results.ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(RES_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(RES_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + CNW'(push) - CNW'(pop);
		end
	end

endmodule

### rtl/core/periodic_sixth_order_derivative.sv
// channel   dir  payload                              handshake
// samples   in   sample (s32 q11.20)                  valid/ready
// results   out  derivative, position, line_done      valid/ready
// cfg       in   cfg_idx, cfg_data                    cfg_we, no wait
//
// one sample per cycle while samples.ready is high; after the line's last
// sample the six leading samples shift back into the window one a cycle
// results pass the derive stages s1, s2, s3 and then a 16-word queue
// samples.ready drops while the burst runs or the queue lacks room for 7 words
// arst_n clears control state, registers return to length 100 and spacing 1.0
module periodic_sixth_order_derivative
	import psod_pkg::*;
#(
	parameter int MAX_LINE_LENGTH = MAX_LINE_LENGTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_idx,
	input  logic [23:0] cfg_data,
	psod_if.sink        samples,
	psod_if.source      results
);

	localparam int CW  = $clog2(MAX_LINE_LENGTH);
	localparam int LW  = ((CW > 13) ? CW : 13) + 1;
	localparam int RW  = $clog2(RES_DEPTH + 1);

	logic [12:0]   line_length_q;
	logic [23:0]   inv_spacing_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] last_n_q;
	logic [2:0]    bcnt_q;
	logic          iss_q;
	tag_t          tag_q;
	logic [RW-1:0] rsv_q;

	logic          accept, step, end_line, win_sh, lead_sh, inc, pop;
	logic [LW-1:0] len_raw, len_eff;
	smp_t          shift_in;
	smp_t          win [WIN_CELLS];
	smp_t          lead [LEAD_CELLS];
	logic          res_valid;
	result_word_t  res;

	assign step           = bcnt_q != '0;
	assign samples.ready  = !step && (rsv_q <= RW'(RSV_LIMIT));
	assign accept         = samples.valid && samples.ready;
	assign shift_in       = accept ? samples.data.sample : lead[0];
	assign win_sh         = accept || step;
	assign lead_sh        = (accept && (cnt_q < CW'(LEAD_CELLS))) || step;
	assign inc            = (accept && (cnt_q >= CW'(LEAD_CELLS))) || step;
	assign pop            = results.valid && results.ready;

	assign len_raw = LW'(line_length_q);
	always_comb begin
		if (len_raw < LW'(MIN_LINE_LENGTH)) begin
			len_eff = LW'(MIN_LINE_LENGTH);
		end else if (len_raw > LW'(MAX_LINE_LENGTH)) begin
			len_eff = LW'(MAX_LINE_LENGTH);
		end else begin
			len_eff = len_raw;
		end
	end
	assign end_line = (LW'(cnt_q) + 1'b1) >= len_eff;

	// window chain, newest sample enters at the top cell
	for (genvar i = 0; i < WIN_CELLS; i++) begin : g_win
		psod_cell u_cell (
			.clk (clk),
			.en  (win_sh),
			.d   ((i == WIN_CELLS - 1) ? shift_in : win[(i + 1) % WIN_CELLS]),
			.q   (win[i])
		);
	end

	// leading samples chain, rotates during the burst
	for (genvar i = 0; i < LEAD_CELLS; i++) begin : g_lead
		psod_cell u_cell (
			.clk (clk),
			.en  (lead_sh),
			.d   ((i == LEAD_CELLS - 1) ? shift_in : lead[(i + 1) % LEAD_CELLS]),
			.q   (lead[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_length_q <= LINE_LENGTH_RST;
			inv_spacing_q <= INV_SPACING_RST;
			cnt_q         <= '0;
			last_n_q      <= '0;
			bcnt_q        <= '0;
			iss_q         <= 1'b0;
			tag_q         <= '0;
			rsv_q         <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_LINE_LENGTH: line_length_q <= cfg_data[12:0];
					REG_INV_SPACING: inv_spacing_q <= cfg_data;
					default: ;
				endcase
			end
			rsv_q <= rsv_q + RW'(inc) - RW'(pop);
			if (accept) begin
				iss_q           <= cnt_q >= CW'(LEAD_CELLS);
				tag_q.position  <= 12'(cnt_q - CW'(3));
				tag_q.line_done <= 1'b0;
				if (end_line) begin
					cnt_q    <= '0;
					last_n_q <= cnt_q;
					bcnt_q   <= 3'd6;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end else if (step) begin
				iss_q  <= 1'b1;
				bcnt_q <= bcnt_q - 1'b1;
				// wrap positions once the tail of the line is covered
				if (bcnt_q > 3'd3) begin
					tag_q.position <= 12'(last_n_q + CW'(4) - CW'(bcnt_q));
				end else begin
					tag_q.position <= 12'(3'd3 - bcnt_q);
				end
				tag_q.line_done <= bcnt_q == 3'd1;
			end else begin
				iss_q <= 1'b0;
			end
		end
	end

	psod_derive u_derive (
		.clk         (clk),
		.arst_n      (arst_n),
		.iss         (iss_q),
		.tag         (tag_q),
		.win         (win),
		.inv_spacing (inv_spacing_q),
		.res_valid   (res_valid),
		.res         (res)
	);

	psod_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.results   (results)
	);

endmodule
